// ===== rtl/core/sxid_pkg.sv =====
// shared types, constants and lookup tables for the strided xor image descrambler
// no dependencies

package sxid_pkg;

   localparam int OFFSET_WIDTH      = 24;
   localparam int SIZE_WIDTH        = 24;
   localparam int BYTE_WIDTH        = 8;
   localparam int TABLE_ENTRIES     = 16;
   localparam int TABLE_INDEX_WIDTH = $clog2(TABLE_ENTRIES);
   localparam int STRIDE_WIDTH      = 4;
   localparam int DIRECTION_WIDTH   = 2;
   localparam int DIV_COUNT_WIDTH   = $clog2(SIZE_WIDTH);
   localparam int WIDE_WIDTH        = (OFFSET_WIDTH > SIZE_WIDTH) ? OFFSET_WIDTH : SIZE_WIDTH;

   localparam int REQ_DATA_WIDTH    = 2 * BYTE_WIDTH;
   localparam int RSP_RAW_WIDTH     = 2 * OFFSET_WIDTH + BYTE_WIDTH + SIZE_WIDTH;
   localparam int RSP_DATA_WIDTH    = ((RSP_RAW_WIDTH + 7) / 8) * 8;

   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = SIZE_WIDTH;

   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef logic [SIZE_WIDTH-1:0]   size_type;
   typedef logic [STRIDE_WIDTH-1:0] stride_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   localparam logic [DIRECTION_WIDTH-1:0] DIR_UPWARD = 2'd1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IMAGE_SIZE    = 3'd0,
      CSR_KEY_SIZE      = 3'd1,
      CSR_START_KEY     = 3'd2,
      CSR_DIRECTION_KEY = 3'd3,
      CSR_STRIDE_KEY    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CTL_IDLE   = 2'd0,
      CTL_DIVIDE = 2'd1,
      CTL_FINISH = 2'd2
   } ctl_state_type;

   typedef struct packed {
      size_type                     image_size;
      size_type                     key_size;
      logic [TABLE_INDEX_WIDTH-1:0] start_key;
      logic [DIRECTION_WIDTH-1:0]   direction_key;
      logic [TABLE_INDEX_WIDTH-1:0] stride_key;
   } cfg_type;

   typedef struct packed {
      logic start_load;
      logic step_load;
      logic div_step;
      logic div_finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   localparam offset_type START_TABLE [TABLE_ENTRIES] = '{
      OFFSET_WIDTH'(20'h5DC00), OFFSET_WIDTH'(20'h5EB00),
      OFFSET_WIDTH'(20'h60900), OFFSET_WIDTH'(20'h73500),
      OFFSET_WIDTH'(20'h86100), OFFSET_WIDTH'(20'hAB900),
      OFFSET_WIDTH'(20'hD1100), OFFSET_WIDTH'(20'hF6900),
      OFFSET_WIDTH'(20'h25800), OFFSET_WIDTH'(20'h4B000),
      OFFSET_WIDTH'(20'h96000), OFFSET_WIDTH'(20'hBB800),
      OFFSET_WIDTH'(20'hE1000), OFFSET_WIDTH'(20'hD7A00),
      OFFSET_WIDTH'(20'hCE400), OFFSET_WIDTH'(20'h79E00)
   };

   localparam stride_type STRIDE_TABLE [TABLE_ENTRIES] = '{
      4'd4, 4'd2, 4'd8, 4'd6, 4'd10, 4'd8, 4'd6, 4'd4,
      4'd2, 4'd2, 4'd8, 4'd6, 4'd4, 4'd6, 4'd8, 4'd10
   };

endpackage

// ===== rtl/core/sxid_csr.sv =====
// configuration register file, written over the csr channel
// depends on sxid_pkg

module sxid_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sxid_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sxid_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output sxid_pkg::cfg_type                    cfg
);

   sxid_pkg::cfg_type cfg_ff;
   sxid_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sxid_pkg::CSR_IMAGE_SIZE:
               cfg_in.image_size = sxid_pkg::SIZE_WIDTH'(csr_data);
            sxid_pkg::CSR_KEY_SIZE:
               cfg_in.key_size = sxid_pkg::SIZE_WIDTH'(csr_data);
            sxid_pkg::CSR_START_KEY:
               cfg_in.start_key = csr_data[sxid_pkg::TABLE_INDEX_WIDTH-1:0];
            sxid_pkg::CSR_DIRECTION_KEY:
               cfg_in.direction_key = csr_data[sxid_pkg::DIRECTION_WIDTH-1:0];
            sxid_pkg::CSR_STRIDE_KEY:
               cfg_in.stride_key = csr_data[sxid_pkg::TABLE_INDEX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_size    <= sxid_pkg::SIZE_WIDTH'(1);
         cfg_ff.key_size      <= sxid_pkg::SIZE_WIDTH'(1);
         cfg_ff.start_key     <= '0;
         cfg_ff.direction_key <= '0;
         cfg_ff.stride_key    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/sxid_ctrl.sv =====
// controller state machine: input and result handshakes, sequencing of the divider
// depends on sxid_pkg

module sxid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_command,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  sxid_pkg::dp_status_type status,
   output sxid_pkg::ctl_cmd_type   cmd
);

   sxid_pkg::ctl_state_type state_ff;
   sxid_pkg::ctl_state_type state_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         sxid_pkg::CTL_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               if (req_command == sxid_pkg::CMD_START) begin
                  cmd.start_load = 1'b1;
                  state_in       = sxid_pkg::CTL_DIVIDE;
               end else begin
                  cmd.step_load = 1'b1;
                  rsp_valid_in  = 1'b1;
               end
            end
         end
         sxid_pkg::CTL_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = sxid_pkg::CTL_FINISH;
            end
         end
         sxid_pkg::CTL_FINISH: begin
            cmd.div_finish = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = sxid_pkg::CTL_IDLE;
         end
         default: begin
            state_in = sxid_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sxid_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/sxid_datapath.sv =====
// datapath: walk state, bit-serial step count divider and result register
// depends on sxid_pkg

module sxid_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  sxid_pkg::cfg_type                         cfg,
   input  sxid_pkg::ctl_cmd_type                     cmd,
   output sxid_pkg::dp_status_type                   status,
   input  logic [sxid_pkg::BYTE_WIDTH-1:0]           req_image_byte,
   input  logic [sxid_pkg::BYTE_WIDTH-1:0]           req_key_byte,
   output sxid_pkg::offset_type                      rsp_write_offset,
   output logic [sxid_pkg::BYTE_WIDTH-1:0]           rsp_out_byte,
   output sxid_pkg::offset_type                      rsp_next_image_offset,
   output sxid_pkg::size_type                        rsp_next_key_offset,
   output logic                                      rsp_last,
   output logic                                      rsp_status
);

   sxid_pkg::offset_type                  offset_ff, offset_in;
   sxid_pkg::stride_type                  stride_ff, stride_in;
   sxid_pkg::size_type                    steps_ff, steps_in;
   sxid_pkg::size_type                    key_index_ff, key_index_in;
   logic                                  running_ff, running_in;

   sxid_pkg::size_type                    quo_ff, quo_in;
   sxid_pkg::stride_type                  rem_ff, rem_in;
   logic [sxid_pkg::DIV_COUNT_WIDTH-1:0]  count_ff, count_in;

   sxid_pkg::offset_type                  wr_off_ff, wr_off_in;
   logic [sxid_pkg::BYTE_WIDTH-1:0]       byte_ff, byte_in;
   sxid_pkg::offset_type                  nxt_off_ff, nxt_off_in;
   sxid_pkg::size_type                    nxt_key_ff, nxt_key_in;
   logic                                  last_ff, last_in;
   logic                                  stat_ff, stat_in;

   logic [sxid_pkg::STRIDE_WIDTH:0]       trial;
   logic                                  trial_ge;
   sxid_pkg::size_type                    step_count;
   sxid_pkg::offset_type                  stride_ext;
   sxid_pkg::offset_type                  size_ext;
   sxid_pkg::offset_type                  off_up;
   sxid_pkg::offset_type                  off_add;
   sxid_pkg::offset_type                  off_down;
   sxid_pkg::offset_type                  off_next;
   sxid_pkg::size_type                    key_inc;
   sxid_pkg::size_type                    key_next;
   sxid_pkg::size_type                    steps_dec;

   assign status.div_done = (count_ff == sxid_pkg::DIV_COUNT_WIDTH'(sxid_pkg::SIZE_WIDTH - 1));

   // restoring division, one quotient bit a cycle
   assign trial    = {rem_ff, quo_ff[sxid_pkg::SIZE_WIDTH-1]};
   assign trial_ge = (trial >= {1'b0, stride_ff});
   assign step_count = quo_ff + sxid_pkg::SIZE_WIDTH'(rem_ff != '0);

   assign stride_ext = sxid_pkg::OFFSET_WIDTH'(stride_ff);
   assign size_ext   = sxid_pkg::OFFSET_WIDTH'(cfg.image_size);

   // upward walk wraps to image_size - stride
   assign off_up  = (offset_ff < stride_ext) ? (size_ext - stride_ext) : (offset_ff - stride_ext);
   assign off_add = offset_ff + stride_ext;
   assign off_down = (sxid_pkg::WIDE_WIDTH'(off_add) > sxid_pkg::WIDE_WIDTH'(cfg.image_size)) ?
                     (off_add - size_ext) : off_add;
   assign off_next = (cfg.direction_key == sxid_pkg::DIR_UPWARD) ? off_up : off_down;

   assign key_inc   = key_index_ff + sxid_pkg::SIZE_WIDTH'(1);
   assign key_next  = (key_inc >= cfg.key_size) ? '0 : key_inc;
   assign steps_dec = steps_ff - sxid_pkg::SIZE_WIDTH'(1);

   always_comb begin
      offset_in    = offset_ff;
      stride_in    = stride_ff;
      steps_in     = steps_ff;
      key_index_in = key_index_ff;
      running_in   = running_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      wr_off_in    = wr_off_ff;
      byte_in      = byte_ff;
      nxt_off_in   = nxt_off_ff;
      nxt_key_in   = nxt_key_ff;
      last_in      = last_ff;
      stat_in      = stat_ff;

      if (cmd.start_load) begin
         offset_in    = sxid_pkg::START_TABLE[cfg.start_key];
         stride_in    = sxid_pkg::STRIDE_TABLE[cfg.stride_key];
         key_index_in = '0;
         quo_in       = cfg.image_size;
         rem_in       = '0;
         count_in     = '0;
      end

      if (cmd.div_step) begin
         quo_in   = {quo_ff[sxid_pkg::SIZE_WIDTH-2:0], trial_ge};
         rem_in   = trial_ge ? sxid_pkg::STRIDE_WIDTH'(trial - {1'b0, stride_ff})
                             : trial[sxid_pkg::STRIDE_WIDTH-1:0];
         count_in = count_ff + sxid_pkg::DIV_COUNT_WIDTH'(1);
      end

      if (cmd.div_finish) begin
         steps_in   = step_count;
         running_in = (step_count != '0);
         wr_off_in  = '0;
         byte_in    = '0;
         nxt_off_in = offset_ff;
         nxt_key_in = key_index_ff;
         last_in    = 1'b0;
         stat_in    = 1'b0;
      end

      if (cmd.step_load) begin
         if (running_ff) begin
            offset_in    = off_next;
            key_index_in = key_next;
            steps_in     = steps_dec;
            running_in   = (steps_dec != '0);
            wr_off_in    = offset_ff;
            byte_in      = req_image_byte ^ req_key_byte;
            nxt_off_in   = off_next;
            nxt_key_in   = key_next;
            last_in      = (steps_dec == '0);
            stat_in      = 1'b0;
         end else begin
            wr_off_in  = '0;
            byte_in    = '0;
            nxt_off_in = offset_ff;
            nxt_key_in = key_index_ff;
            last_in    = 1'b0;
            stat_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         stride_ff    <= '0;
         steps_ff     <= '0;
         key_index_ff <= '0;
         running_ff   <= 1'b0;
         count_ff     <= '0;
      end else begin
         offset_ff    <= offset_in;
         stride_ff    <= stride_in;
         steps_ff     <= steps_in;
         key_index_ff <= key_index_in;
         running_ff   <= running_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      wr_off_ff  <= wr_off_in;
      byte_ff    <= byte_in;
      nxt_off_ff <= nxt_off_in;
      nxt_key_ff <= nxt_key_in;
      last_ff    <= last_in;
      stat_ff    <= stat_in;
   end

   assign rsp_write_offset      = wr_off_ff;
   assign rsp_out_byte          = byte_ff;
   assign rsp_next_image_offset = nxt_off_ff;
   assign rsp_next_key_offset   = nxt_key_ff;
   assign rsp_last              = last_ff;
   assign rsp_status            = stat_ff;

endmodule

// ===== rtl/core/strided_xor_image_descrambler_top.sv =====
// Strided xor image descrambler, top level.
// Depends on sxid_pkg, sxid_csr, sxid_ctrl and sxid_datapath.
//
// Usage:
//   csr channel writes image_size, key_size, start_key, direction_key and
//   stride_key by index 0 to 4; it is always ready, writes take one beat.
//   req beats carry a command in tuser (0 start a run, 1 one step) and the
//   image and key bytes read at the offsets given out by the previous result.
//   Every req beat gives exactly one rsp beat with the write offset, the xor
//   byte, the next image and key offsets, tlast on the final step of a run
//   and tuser set when a step arrives with no run active.
// Timing:
//   a step beat gives its result in the cycle after acceptance, and steps
//   stream at one beat per cycle while rsp_tready stays high.
//   a start beat gives its result after the divide and finish states: the step
//   count is found by a bit-serial divider, one quotient bit per cycle.
// Reset clears the walk state and the result valid flag; the csr registers
// return to image_size 1, key_size 1 and zero keys.
// When rsp_tready is low the result is held and req_tready drops once the
// result register is full, so no beat is lost.

module strided_xor_image_descrambler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // image_byte [7:0], key_byte [15:8]
   input  logic [sxid_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // command
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // write_offset, out_byte, next_image_offset, next_key_offset
   output logic [sxid_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // status
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sxid_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sxid_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   sxid_pkg::cfg_type               cfg;
   sxid_pkg::ctl_cmd_type           cmd;
   sxid_pkg::dp_status_type         status;
   sxid_pkg::offset_type            write_offset;
   logic [sxid_pkg::BYTE_WIDTH-1:0] out_byte;
   sxid_pkg::offset_type            next_image_offset;
   sxid_pkg::size_type              next_key_offset;

   sxid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sxid_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   sxid_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .status                (status),
      .req_image_byte        (req_tdata[sxid_pkg::BYTE_WIDTH-1:0]),
      .req_key_byte          (req_tdata[2*sxid_pkg::BYTE_WIDTH-1:sxid_pkg::BYTE_WIDTH]),
      .rsp_write_offset      (write_offset),
      .rsp_out_byte          (out_byte),
      .rsp_next_image_offset (next_image_offset),
      .rsp_next_key_offset   (next_key_offset),
      .rsp_last              (rsp_tlast),
      .rsp_status            (rsp_tuser)
   );

   assign rsp_tdata = sxid_pkg::RSP_DATA_WIDTH'({next_key_offset, next_image_offset,
                                                 out_byte, write_offset});

endmodule

// ===== bench/strided_xor_image_descrambler_top_test.sv =====
// self-checking bench for the strided xor image descrambler top level
// depends on sxid_pkg and strided_xor_image_descrambler_top; beats are checked
// against a cycle-free model of the offset walk, the key cycle and the xor

module strided_xor_image_descrambler_top_test;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASE_BEATS = 50;
   localparam int RANDOM_PHASES = 8;

   localparam sxid_pkg::offset_type WALK_START [sxid_pkg::TABLE_ENTRIES] = '{
      24'h05DC00, 24'h05EB00, 24'h060900, 24'h073500,
      24'h086100, 24'h0AB900, 24'h0D1100, 24'h0F6900,
      24'h025800, 24'h04B000, 24'h096000, 24'h0BB800,
      24'h0E1000, 24'h0D7A00, 24'h0CE400, 24'h079E00
   };
   localparam sxid_pkg::stride_type WALK_STRIDE [sxid_pkg::TABLE_ENTRIES] = '{
      4'd4, 4'd2, 4'd8, 4'd6, 4'd10, 4'd8, 4'd6, 4'd4,
      4'd2, 4'd2, 4'd8, 4'd6, 4'd4, 4'd6, 4'd8, 4'd10
   };

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   typedef struct {
      sxid_pkg::command_type command;
      logic [7:0]            image_byte;
      logic [7:0]            key_byte;
   } step_beat_type;

   typedef struct {
      sxid_pkg::csr_index_type index;
      sxid_pkg::size_type      value;
   } reg_write_type;

   typedef struct packed {
      sxid_pkg::offset_type write_offset;
      logic [7:0]           out_byte;
      sxid_pkg::offset_type next_image_offset;
      sxid_pkg::size_type   next_key_offset;
      logic                 last;
      logic                 status;
   } xor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [sxid_pkg::REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                                 req_tuser = 1'b0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [sxid_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                 rsp_tuser;
   logic                                 rsp_tlast;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [sxid_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [sxid_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   strided_xor_image_descrambler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #5 clock = ~clock;

   // model state
   sxid_pkg::cfg_type    live_cfg;
   sxid_pkg::offset_type walk_offset;
   sxid_pkg::stride_type walk_stride;
   sxid_pkg::size_type   steps_left;
   sxid_pkg::size_type   key_pos;
   logic                 walking;

   step_beat_type  beats_to_send [$];
   reg_write_type  writes_to_send [$];
   xor_result_type expected_xor_results [$];

   flow_mode_type flow = FLOW_FREE;
   int  hold_off_left = 0;
   logic long_hold_armed = 1'b0;
   logic long_hold_started = 1'b0;
   logic req_took = 1'b0;
   logic csr_took = 1'b0;
   int  beats_queued = 0;
   int  beats_checked = 0;
   int  writes_queued = 0;
   int  writes_done = 0;
   int  mismatches = 0;
   int  runs_finished = 0;
   int  idle_steps = 0;
   int  quiet_cycles = 0;

   // generator's view of the settings
   sxid_pkg::size_type gen_image_size = 24'd1;
   logic [3:0]         gen_stride_key = 4'd0;

   step_beat_type  next_beat;
   reg_write_type  next_write;
   xor_result_type got_result;

   function automatic void clear_model();
      live_cfg = '0;
      live_cfg.image_size = 24'd1;
      live_cfg.key_size = 24'd1;
      walk_offset = '0;
      walk_stride = '0;
      steps_left = '0;
      key_pos = '0;
      walking = 1'b0;
   endfunction

   function automatic void apply_reg(logic [sxid_pkg::CSR_INDEX_WIDTH-1:0] index,
                                     logic [sxid_pkg::CSR_DATA_WIDTH-1:0] value);
      case (sxid_pkg::csr_index_type'(index))
         sxid_pkg::CSR_IMAGE_SIZE:    live_cfg.image_size = value;
         sxid_pkg::CSR_KEY_SIZE:      live_cfg.key_size = value;
         sxid_pkg::CSR_START_KEY:     live_cfg.start_key = value[3:0];
         sxid_pkg::CSR_DIRECTION_KEY: live_cfg.direction_key = value[1:0];
         sxid_pkg::CSR_STRIDE_KEY:    live_cfg.stride_key = value[3:0];
         default: ;
      endcase
   endfunction

   function automatic xor_result_type predict_xor(sxid_pkg::command_type command,
                                                  logic [7:0] image_byte,
                                                  logic [7:0] key_byte);
      xor_result_type     r;
      logic [31:0]        count;
      sxid_pkg::size_type next_key;
      r = '0;
      if (command == sxid_pkg::CMD_START) begin
         walk_offset = WALK_START[live_cfg.start_key];
         walk_stride = WALK_STRIDE[live_cfg.stride_key];
         count = (32'(live_cfg.image_size) + 32'(walk_stride) - 32'd1) / 32'(walk_stride);
         steps_left = sxid_pkg::size_type'(count);
         key_pos = '0;
         walking = (count != 32'd0);
      end else if (!walking) begin
         r.status = 1'b1;
      end else begin
         r.write_offset = walk_offset;
         r.out_byte = image_byte ^ key_byte;
         next_key = key_pos + 24'd1;
         key_pos = (next_key >= live_cfg.key_size) ? '0 : next_key;
         if (live_cfg.direction_key == sxid_pkg::DIR_UPWARD) begin
            if (walk_offset < sxid_pkg::offset_type'(walk_stride))
               walk_offset = sxid_pkg::offset_type'(live_cfg.image_size -
                                                    sxid_pkg::size_type'(walk_stride));
            else
               walk_offset = walk_offset - sxid_pkg::offset_type'(walk_stride);
         end else begin
            walk_offset = walk_offset + sxid_pkg::offset_type'(walk_stride);
            if (walk_offset > sxid_pkg::offset_type'(live_cfg.image_size))
               walk_offset = walk_offset - sxid_pkg::offset_type'(live_cfg.image_size);
         end
         steps_left = steps_left - 24'd1;
         if (steps_left == '0) begin
            r.last = 1'b1;
            walking = 1'b0;
         end
      end
      r.next_image_offset = walk_offset;
      r.next_key_offset = key_pos;
      return r;
   endfunction

   task automatic report(string what);
      mismatches++;
      $display("MISMATCH: %s", what);
   endtask

   task automatic check_result(xor_result_type got, xor_result_type want);
      if (got.write_offset !== want.write_offset)
         report($sformatf("write_offset at beat %0d: got %0h want %0h",
                          beats_checked, got.write_offset, want.write_offset));
      if (got.out_byte !== want.out_byte)
         report($sformatf("out_byte at beat %0d: got %0h want %0h",
                          beats_checked, got.out_byte, want.out_byte));
      if (got.next_image_offset !== want.next_image_offset)
         report($sformatf("next_image_offset at beat %0d: got %0h want %0h",
                          beats_checked, got.next_image_offset, want.next_image_offset));
      if (got.next_key_offset !== want.next_key_offset)
         report($sformatf("next_key_offset at beat %0d: got %0h want %0h",
                          beats_checked, got.next_key_offset, want.next_key_offset));
      if (got.last !== want.last)
         report($sformatf("last at beat %0d: got %0b want %0b",
                          beats_checked, got.last, want.last));
      if (got.status !== want.status)
         report($sformatf("status at beat %0d: got %0b want %0b",
                          beats_checked, got.status, want.status));
   endtask

   function automatic bit sender_idles();
      case (flow)
         FLOW_SENDER_IDLE: return $urandom_range(99) < 75;
         FLOW_BOTH:        return $urandom_range(99) < 18;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (flow)
         FLOW_RECEIVER_STALL: return $urandom_range(99) < 75;
         FLOW_BOTH:           return $urandom_range(99) < 18;
         default:             return 1'b0;
      endcase
   endfunction

   // beat driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (beats_to_send.size() != 0 && !sender_idles()) begin
            next_beat = beats_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {next_beat.key_byte, next_beat.image_byte};
            req_tuser <= next_beat.command;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // register write driver
   always @(negedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_took) begin
         if (writes_to_send.size() != 0) begin
            next_write = writes_to_send.pop_front();
            csr_valid <= 1'b1;
            csr_index <= next_write.index;
            csr_data <= next_write.value;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off once armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_armed && !long_hold_started) begin
         rsp_tready <= 1'b0;
         hold_off_left <= HOLD_OFF_CYCLES - 1;
         long_hold_started <= 1'b1;
      end else if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         csr_took <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_data);
            writes_done++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_result.write_offset = rsp_tdata[23:0];
            got_result.out_byte = rsp_tdata[31:24];
            got_result.next_image_offset = rsp_tdata[55:32];
            got_result.next_key_offset = rsp_tdata[79:56];
            got_result.last = rsp_tlast;
            got_result.status = rsp_tuser;
            if (expected_xor_results.size() == 0)
               report($sformatf("result beat %0d with nothing expected", beats_checked));
            else
               check_result(got_result, expected_xor_results.pop_front());
            runs_finished += rsp_tlast;
            idle_steps += rsp_tuser;
            beats_checked++;
         end
         if (req_tvalid && req_tready)
            expected_xor_results.push_back(predict_xor(sxid_pkg::command_type'(req_tuser),
                                                       req_tdata[7:0], req_tdata[15:8]));
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_reg(sxid_pkg::csr_index_type index, sxid_pkg::size_type value);
      reg_write_type w;
      w.index = index;
      w.value = value;
      writes_to_send.push_back(w);
      writes_queued++;
      if (index == sxid_pkg::CSR_IMAGE_SIZE)
         gen_image_size = value;
      if (index == sxid_pkg::CSR_STRIDE_KEY)
         gen_stride_key = value[3:0];
   endtask

   task automatic queue_beat(sxid_pkg::command_type command, logic [7:0] image_byte,
                             logic [7:0] key_byte);
      step_beat_type b;
      b.command = command;
      b.image_byte = image_byte;
      b.key_byte = key_byte;
      beats_to_send.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_start();
      queue_beat(sxid_pkg::CMD_START, 8'($urandom), 8'($urandom));
   endtask

   task automatic queue_step();
      queue_beat(sxid_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
   endtask

   task automatic settle();
      while (writes_done < writes_queued || beats_checked < beats_queued)
         @(negedge clock);
   endtask

   task automatic program_random_setting();
      int unsigned pick;
      logic [3:0]  start_key;
      start_key = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 60)
         set_reg(sxid_pkg::CSR_IMAGE_SIZE, sxid_pkg::size_type'($urandom_range(1, 64)));
      else if (pick < 65)
         set_reg(sxid_pkg::CSR_IMAGE_SIZE, '0);
      else if (pick < 82)
         set_reg(sxid_pkg::CSR_IMAGE_SIZE,
                 WALK_START[start_key] + sxid_pkg::size_type'($urandom_range(0, 12)));
      else
         set_reg(sxid_pkg::CSR_IMAGE_SIZE,
                 sxid_pkg::size_type'($urandom_range(1, 24'hFFFFFF)));
      if ($urandom_range(99) < 40)
         set_reg(sxid_pkg::CSR_KEY_SIZE, sxid_pkg::size_type'($urandom_range(0, 5)));
      else
         set_reg(sxid_pkg::CSR_KEY_SIZE,
                 sxid_pkg::size_type'($urandom_range(0, 24'hFFFFFF)));
      set_reg(sxid_pkg::CSR_START_KEY, sxid_pkg::size_type'(start_key));
      set_reg(sxid_pkg::CSR_DIRECTION_KEY, sxid_pkg::size_type'($urandom_range(0, 3)));
      set_reg(sxid_pkg::CSR_STRIDE_KEY, sxid_pkg::size_type'($urandom_range(0, 15)));
   endtask

   // mostly whole runs with random bytes, some overrun steps, restarts and noise
   task automatic queue_random_beats(int target);
      int sent;
      int run_steps;
      int unsigned run_count;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 85) begin
            run_count = (32'(gen_image_size) + 32'(WALK_STRIDE[gen_stride_key]) - 1) /
                        32'(WALK_STRIDE[gen_stride_key]);
            if (run_count != 0 && run_count <= 40)
               run_steps = run_count + $urandom_range(0, 2);
            else
               run_steps = $urandom_range(1, 20);
            if ($urandom_range(99) < 10)
               run_steps = $urandom_range(0, run_steps);
            queue_start();
            repeat (run_steps) queue_step();
            sent += run_steps + 1;
         end else begin
            queue_beat(sxid_pkg::command_type'($urandom_range(0, 1)),
                       8'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      clear_model();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset settings: idle step, one-step run, step after the end
      queue_beat(sxid_pkg::CMD_STEP, 8'hFF, 8'h00);
      queue_start();
      queue_beat(sxid_pkg::CMD_STEP, 8'h00, 8'hFF);
      queue_beat(sxid_pkg::CMD_STEP, 8'hA5, 8'h5A);
      settle();

      // empty image never starts a run
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, '0);
      settle();
      queue_start();
      queue_step();
      settle();

      // downward wrap to a small offset, then upward below the stride
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, 24'h05DC01);
      set_reg(sxid_pkg::CSR_STRIDE_KEY, 24'd1);
      set_reg(sxid_pkg::CSR_KEY_SIZE, 24'd3);
      set_reg(sxid_pkg::CSR_START_KEY, 24'd0);
      settle();
      queue_start();
      queue_step();
      settle();
      set_reg(sxid_pkg::CSR_DIRECTION_KEY, sxid_pkg::size_type'(sxid_pkg::DIR_UPWARD));
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, 24'd1);
      settle();
      queue_step();
      queue_step();
      settle();
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, 24'h05DC01);
      settle();
      queue_step();
      settle();

      // direction code 3, offset landing on the image size, key size zero
      set_reg(sxid_pkg::CSR_DIRECTION_KEY, 24'd3);
      set_reg(sxid_pkg::CSR_KEY_SIZE, '0);
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, 24'h05DC02);
      settle();
      queue_start();
      queue_step();
      queue_step();
      settle();

      // top table entries and largest sizes
      set_reg(sxid_pkg::CSR_DIRECTION_KEY, 24'd2);
      set_reg(sxid_pkg::CSR_START_KEY, 24'd15);
      set_reg(sxid_pkg::CSR_STRIDE_KEY, 24'd15);
      set_reg(sxid_pkg::CSR_KEY_SIZE, 24'hFFFFFF);
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, 24'hFFFFFF);
      settle();
      queue_start();
      queue_beat(sxid_pkg::CMD_STEP, 8'hFF, 8'hFF);
      queue_beat(sxid_pkg::CMD_STEP, 8'h00, 8'h00);
      settle();

      // short upward run to its end, then a restart in the middle of a run
      set_reg(sxid_pkg::CSR_IMAGE_SIZE, 24'd20);
      set_reg(sxid_pkg::CSR_STRIDE_KEY, 24'd4);
      set_reg(sxid_pkg::CSR_START_KEY, 24'd8);
      set_reg(sxid_pkg::CSR_DIRECTION_KEY, sxid_pkg::size_type'(sxid_pkg::DIR_UPWARD));
      set_reg(sxid_pkg::CSR_KEY_SIZE, 24'd2);
      settle();
      queue_start();
      queue_step();
      queue_step();
      queue_step();
      queue_start();
      queue_step();
      queue_start();
      queue_step();
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_random_setting();
         settle();
         flow = flow_mode_type'(phase % 4);
         if (phase == 4)
            long_hold_armed = 1'b1;
         queue_random_beats(PHASE_BEATS);
         settle();
      end
      flow = FLOW_FREE;

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_xor_results.size() != 0)
         report($sformatf("%0d results never arrived", expected_xor_results.size()));

      $display("run covered %0d request beats and %0d register writes in %0d phases",
               beats_queued, writes_queued, RANDOM_PHASES + 1);
      $display("%0d runs reached their final step, %0d steps arrived with no run active",
               runs_finished, idle_steps);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
